// File: src/utf8lb_pkg.sv
// Shared types, codes and helper functions for the UTF-8 capped line buffer.
package utf8lb_pkg;

    // Operation codes carried in a request.
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_BACK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_PENDING = 3'd1;
    localparam logic [2:0] ST_REFUSED = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_READ    = 3'd4;

    // Configuration register indexes.
    localparam logic REG_BYTE_CAP = 1'b0;
    localparam logic REG_CP_CAP   = 1'b1;

    localparam logic [5:0] BYTE_CAP_RST = 6'd48;
    localparam logic [5:0] CP_CAP_RST   = 6'd16;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] byte_value;
        logic [5:0] read_index;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] byte_count;
        logic [5:0] code_point_count;
        logic [7:0] read_byte;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_req;
        logic       push_seq;
        logic       commit_wr;
        logic       commit_fin;
        logic       drop_pend;
        logic       cut_init;
        logic       rd_cut;
        logic       cut_dec;
        logic       bs_fin;
        logic       clear_all;
        logic       rd_req;
        logic       set_status;
        logic [2:0] status_code;
        logic       out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] opcode;
        logic       seq_done;
        logic       refuse;
        logic       pend_active;
        logic       bytes_zero;
        logic       cut_zero;
        logic       cont_data;
        logic       last_commit;
    } sts_t;

    function automatic logic is_cont(input logic [7:0] b);
        return (b & 8'hC0) == 8'h80;
    endfunction

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        if ((b & 8'h80) == 8'h00)      len = 3'd1;
        else if ((b & 8'hE0) == 8'hC0) len = 3'd2;
        else if ((b & 8'hF0) == 8'hE0) len = 3'd3;
        else if ((b & 8'hF8) == 8'hF0) len = 3'd4;
        else                           len = 3'd1;
        return len;
    endfunction

endpackage

// File: src/utf8lb_dp.sv
// Datapath: request latch, pending sequence, counters, text memory and result register.
module utf8lb_dp
    import utf8lb_pkg::*;
#(
    parameter int STORE_DEPTH = 48
) (
    input  logic       clk,
    input  logic       rst_n,
    input  req_t       req_data,
    input  logic       cfg_wr,
    input  logic       cfg_index,
    input  logic [5:0] cfg_data,
    input  cmd_t       cmd,
    output sts_t       sts,
    output rsp_t       rsp_data
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CAP_LIM = (STORE_DEPTH > 63) ? 63 : STORE_DEPTH;
    localparam logic [5:0] CAP_LIM_V = 6'(CAP_LIM);

    req_t       req_reg;
    logic [5:0] byte_cap_reg, byte_cap_next;
    logic [5:0] cp_cap_reg, cp_cap_next;
    logic [5:0] bytes_reg, bytes_next;
    logic [5:0] points_reg, points_next;
    logic [2:0] pend_target_reg, pend_target_next;
    logic [2:0] pend_count_reg, pend_count_next;
    logic [7:0] pend_bytes_reg [4];
    logic [2:0] len_reg;
    logic [1:0] k_reg;
    logic [5:0] cut_reg;
    logic [2:0] status_reg;
    logic       rd_hit_reg;
    logic [7:0] rd_data_reg;
    rsp_t       rsp_reg;

    logic [7:0] text_store [STORE_DEPTH];

    logic       keep_seq;
    logic [2:0] tgt_eff;
    logic [2:0] cnt_eff;
    logic [2:0] new_cnt;
    logic [5:0] eff_cap;
    logic [6:0] want_sum;
    logic [6:0] wr_sum;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic       rd_en;

    // A pending sequence survives only if the new byte continues it.
    assign keep_seq = (pend_target_reg != 3'd0) && is_cont(req_reg.byte_value);
    assign tgt_eff  = keep_seq ? pend_target_reg : lead_len(req_reg.byte_value);
    assign cnt_eff  = keep_seq ? pend_count_reg : 3'd0;
    assign new_cnt  = cnt_eff + 3'd1;

    assign eff_cap  = (byte_cap_reg > CAP_LIM_V) ? CAP_LIM_V : byte_cap_reg;
    assign want_sum = {1'b0, bytes_reg} + 7'(tgt_eff);
    assign wr_sum   = {1'b0, bytes_reg} + 7'(k_reg);
    assign wr_addr  = AW'(wr_sum);
    assign rd_addr  = cmd.rd_cut ? AW'(cut_reg) : AW'(req_reg.read_index);
    assign rd_en    = cmd.rd_cut || cmd.rd_req;

    always_comb
    begin
        sts.opcode      = req_reg.opcode;
        sts.seq_done    = new_cnt >= tgt_eff;
        sts.refuse      = (points_reg >= cp_cap_reg) || (want_sum > {1'b0, eff_cap});
        sts.pend_active = pend_target_reg != 3'd0;
        sts.bytes_zero  = bytes_reg == 6'd0;
        sts.cut_zero    = cut_reg == 6'd0;
        sts.cont_data   = is_cont(rd_data_reg);
        sts.last_commit = ({1'b0, k_reg} + 3'd1) == len_reg;
    end

    always_comb
    begin
        byte_cap_next    = byte_cap_reg;
        cp_cap_next      = cp_cap_reg;
        bytes_next       = bytes_reg;
        points_next      = points_reg;
        pend_target_next = pend_target_reg;
        pend_count_next  = pend_count_reg;

        if (cfg_wr)
        begin
            case (cfg_index)
                REG_BYTE_CAP: byte_cap_next = cfg_data;
                REG_CP_CAP:   cp_cap_next   = cfg_data;
                default:      byte_cap_next = byte_cap_reg;
            endcase
        end

        if (cmd.push_seq)
        begin
            if (new_cnt >= tgt_eff)
            begin
                pend_target_next = 3'd0;
                pend_count_next  = 3'd0;
            end
            else
            begin
                pend_target_next = tgt_eff;
                pend_count_next  = new_cnt;
            end
        end

        if (cmd.drop_pend || cmd.clear_all)
        begin
            pend_target_next = 3'd0;
            pend_count_next  = 3'd0;
        end

        if (cmd.commit_fin)
        begin
            bytes_next  = bytes_reg + 6'(len_reg);
            points_next = points_reg + 6'd1;
        end

        if (cmd.bs_fin)
        begin
            bytes_next = cut_reg;
            if (points_reg != 6'd0)
            begin
                points_next = points_reg - 6'd1;
            end
        end

        if (cmd.clear_all)
        begin
            bytes_next  = 6'd0;
            points_next = 6'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cap_reg    <= BYTE_CAP_RST;
            cp_cap_reg      <= CP_CAP_RST;
            bytes_reg       <= 6'd0;
            points_reg      <= 6'd0;
            pend_target_reg <= 3'd0;
            pend_count_reg  <= 3'd0;
        end
        else
        begin
            byte_cap_reg    <= byte_cap_next;
            cp_cap_reg      <= cp_cap_next;
            bytes_reg       <= bytes_next;
            points_reg      <= points_next;
            pend_target_reg <= pend_target_next;
            pend_count_reg  <= pend_count_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req_data;
        end
        if (cmd.push_seq)
        begin
            pend_bytes_reg[cnt_eff[1:0]] <= req_reg.byte_value;
            len_reg <= tgt_eff;
            k_reg   <= 2'd0;
        end
        else if (cmd.commit_wr)
        begin
            k_reg <= k_reg + 2'd1;
        end
        if (cmd.cut_init)
        begin
            cut_reg <= bytes_reg - 6'd1;
        end
        else if (cmd.cut_dec)
        begin
            cut_reg <= cut_reg - 6'd1;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status_code;
            rd_hit_reg <= cmd.rd_req && (req_reg.read_index < bytes_reg);
        end
        if (cmd.out_load)
        begin
            rsp_reg.status           <= status_reg;
            rsp_reg.byte_count       <= bytes_reg;
            rsp_reg.code_point_count <= points_reg;
            rsp_reg.read_byte        <= rd_hit_reg ? rd_data_reg : 8'd0;
        end
    end

    // Single-port text memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (cmd.commit_wr)
        begin
            text_store[wr_addr] <= pend_bytes_reg[k_reg];
        end
        if (rd_en)
        begin
            rd_data_reg <= text_store[rd_addr];
        end
    end

    assign rsp_data = rsp_reg;

    a_pend_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_target_reg != 3'd0) |-> (pend_count_reg < pend_target_reg))
        else $error("pending count not below its target");

    a_bytes_lim: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_reg <= CAP_LIM_V)
        else $error("committed bytes beyond the store");

    a_commit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit_wr |-> (pend_target_reg == 3'd0 && len_reg != 3'd0))
        else $error("commit while a sequence is still pending");

endmodule

// File: src/utf8lb_ctrl.sv
// Controller state machine that sequences each request through the datapath.
module utf8lb_ctrl
    import utf8lb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    output logic rsp_valid,
    input  logic rsp_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_COMMIT,
        S_BS_READ,
        S_BS_TEST,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   slot_free;

    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign req_stall = state_reg != S_IDLE;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (sts.opcode)
                    OP_PUSH:
                    begin
                        cmd.push_seq = 1'b1;
                        if (!sts.seq_done)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_PENDING;
                            state_next      = S_FINISH;
                        end
                        else if (sts.refuse)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_REFUSED;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_COMMIT;
                        end
                    end
                    OP_BACK:
                    begin
                        cmd.set_status = 1'b1;
                        if (sts.pend_active)
                        begin
                            cmd.drop_pend   = 1'b1;
                            cmd.status_code = ST_DONE;
                            state_next      = S_FINISH;
                        end
                        else if (sts.bytes_zero)
                        begin
                            cmd.status_code = ST_EMPTY;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            cmd.cut_init    = 1'b1;
                            cmd.status_code = ST_DONE;
                            state_next      = S_BS_READ;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.clear_all   = 1'b1;
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_DONE;
                        state_next      = S_FINISH;
                    end
                    default:
                    begin
                        cmd.rd_req      = 1'b1;
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_READ;
                        state_next      = S_FINISH;
                    end
                endcase
            end
            S_COMMIT:
            begin
                cmd.commit_wr = 1'b1;
                if (sts.last_commit)
                begin
                    cmd.commit_fin  = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_DONE;
                    state_next      = S_FINISH;
                end
            end
            S_BS_READ:
            begin
                // The walk never tests the byte at position zero.
                if (sts.cut_zero)
                begin
                    cmd.bs_fin = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.rd_cut = 1'b1;
                    state_next = S_BS_TEST;
                end
            end
            S_BS_TEST:
            begin
                if (sts.cont_data)
                begin
                    cmd.cut_dec = 1'b1;
                    state_next  = S_BS_READ;
                end
                else
                begin
                    cmd.bs_fin = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == S_EXEC))
        else $error("accepted request did not move to execution");

    a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && slot_free) |=> (rsp_valid_reg && state_reg == S_IDLE))
        else $error("finished request did not produce a result");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> slot_free)
        else $error("result register overwritten before it was taken");

endmodule

// File: src/utf8lb_top.sv
// Top level of the UTF-8 capped line buffer: ports, configuration and wiring.
//
// The buffer takes one request at a time and gives exactly one result for it.
// Clear, read, a refused or still-pending push, a backspace on an empty buffer
// and a backspace that only drops a pending sequence go from the execute state
// straight to the finish state. A push that completes a code point of n bytes
// first passes through the commit state, since the single-port text memory is
// written one byte per cycle. A backspace that removes a committed code point
// walks back over the stored bytes, reading each from memory and then testing
// it; the walk stops on a byte that is not a continuation byte or when it
// reaches position zero, which it does not test. The result register lets a
// new request be accepted while the previous result is still waiting; the next
// result waits for it to be taken. Configuration writes are accepted in every cycle.
module utf8_capped_line_buffer_top
    import utf8lb_pkg::*;
#(
    parameter int STORE_DEPTH = 48
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  req_t       req_data,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output rsp_t       rsp_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [5:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;
    logic cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    utf8lb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    utf8lb_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cfg_wr    (cfg_wr),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_data  (rsp_data)
    );

endmodule
